/* hdl/insertion_sorter_assert.svh */
// ----------------------------------------------------------------------------
// Insertion sorter assertion macros
// Shared concurrent assertion wrappers; NO_ASSERTIONS leaves them empty.
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every rising clock edge outside reset.
`define ISORT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("insertion sorter assertion failed");

// The expression must never be true outside reset.
`define ISORT_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("insertion sorter forbidden condition seen");

`else

`define ISORT_ASSERT(lbl, clk, rst, prop)
`define ISORT_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

/* hdl/isort_pkg.sv */
// ----------------------------------------------------------------------------
// Insertion sorter package
// Sizes, request and control types shared by the sorter modules.
// ----------------------------------------------------------------------------
package isort_pkg;

   // Element width and number of cells in the insertion chain.
   localparam int DATA_W   = 32;
   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Request queue between the front and the back; depth is a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One queued request.
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     end_of_set;
   } req_item_type;

   // Commands from the back controller to the insertion chain.
   typedef struct packed {
      logic insert;
      logic shift_out;
   } chain_ctrl_type;

   // Status of the insertion chain.
   typedef struct packed {
      logic signed [DATA_W-1:0] head;
      logic [CNT_W-1:0]         count;
      logic                     full;
   } chain_status_type;

   // Back controller state.
   typedef enum logic [1:0] {
      ST_INSERT = 2'b01,
      ST_DRAIN  = 2'b10
   } back_state_type;

endpackage

/* hdl/isort_queue.sv */
// ----------------------------------------------------------------------------
// Insertion sorter request queue
// Small FIFO that lets the front accept requests while the back drains.
// ----------------------------------------------------------------------------
module isort_queue import isort_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         pop_valid,
   output req_item_type pop_item
);

   req_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // Occupancy and head of the queue.
   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/isort_chain.sv */
// ----------------------------------------------------------------------------
// Insertion sorter cell chain
// Row of cells kept in ascending order; inserts in place, drains from
// the head one element per cycle while shift_out is asserted.
// ----------------------------------------------------------------------------
module isort_chain import isort_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  chain_ctrl_type           chain_ctrl,
   input  logic signed [DATA_W-1:0] ins_value,
   output chain_status_type         chain_status
);

   logic signed [DATA_W-1:0] cell_ff [CAPACITY];
   logic signed [DATA_W-1:0] cell_in [CAPACITY];
   logic [CAPACITY-1:0]      take;
   logic [CNT_W-1:0]         count_ff, count_in;

   // Each cell decides locally: an empty cell or one holding a larger value
   // makes room, so equal values stay ahead of the newcomer.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      assign take[g] = (CNT_W'(g) >= count_ff) || (cell_ff[g] > ins_value);

      if (g == 0) begin : g_head
         always_comb begin
            cell_in[g] = cell_ff[g];
            if (chain_ctrl.insert) begin
               if (take[g]) begin
                  cell_in[g] = ins_value;
               end
            end else if (chain_ctrl.shift_out) begin
               cell_in[g] = (CAPACITY > 1) ? cell_ff[(CAPACITY > 1) ? 1 : 0] : cell_ff[g];
            end
         end
      end else begin : g_body
         always_comb begin
            cell_in[g] = cell_ff[g];
            if (chain_ctrl.insert) begin
               if (take[g]) begin
                  cell_in[g] = take[g-1] ? cell_ff[g-1] : ins_value;
               end
            end else if (chain_ctrl.shift_out) begin
               cell_in[g] = cell_ff[(g < CAPACITY - 1) ? g + 1 : g];
            end
         end
      end
   end

   // Cell contents carry no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // Fill count follows inserts and drains.
   always_comb begin
      count_in = count_ff;
      if (chain_ctrl.insert && !chain_status.full) begin
         count_in = count_ff + CNT_W'(1);
      end else if (chain_ctrl.shift_out) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign chain_status.head  = cell_ff[0];
   assign chain_status.count = count_ff;
   assign chain_status.full  = (count_ff == CNT_W'(CAPACITY));

endmodule

/* hdl/insertion_sorter.sv */
// ----------------------------------------------------------------------------
// Insertion sorter
// Stable ascending sort of signed 32-bit elements, emitted per data set.
// ----------------------------------------------------------------------------
// Each request carries one element; it passes a four-entry request queue
// and is inserted into a chain of CAPACITY cells, so a set is taken at one
// request per cycle while the queue holds requests. The request marked
// end_of_set is inserted likewise, after which the chain drains through its
// head cell, one result per cycle while the result side does not stall. A
// dropped element still takes its turn at insertion, and no request leaves
// the queue during the drain (the queue still accepts up to four). Elements
// arriving at a full chain are dropped and every result of that set carries
// overflow; the last result carries final_res.
// ----------------------------------------------------------------------------
`include "insertion_sorter_assert.svh"

module insertion_sorter import isort_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [DATA_W-1:0] req_value,
   input  logic                     req_end_of_set,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_sorted_value,
   output logic                     rsp_final_res,
   output logic                     rsp_overflow
);

   req_item_type             push_item;
   req_item_type             q_item;
   logic                     q_full;
   logic                     q_valid;
   logic                     push;
   logic                     pop;
   chain_ctrl_type           chain_ctrl;
   chain_status_type         chain_status;
   back_state_type           state_ff, state_in;
   logic                     dropped_ff, dropped_in;
   logic                     out_free;
   logic                     drain_fire;
   logic                     last_out;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_sorted_value_ff;
   logic                     rsp_final_res_ff;
   logic                     rsp_overflow_ff;

   // Front: accept requests into the queue.
   assign push                 = req_valid && !req_stall;
   assign req_stall            = q_full;
   assign push_item.value      = req_value;
   assign push_item.end_of_set = req_end_of_set;

   isort_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (pop),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   // Back: insert while collecting a set, drain once its last request is in.
   assign pop                  = q_valid && (state_ff == ST_INSERT);
   assign out_free             = !rsp_valid_ff || !rsp_stall;
   assign drain_fire           = (state_ff == ST_DRAIN) && out_free;
   assign last_out             = (chain_status.count == CNT_W'(1));
   assign chain_ctrl.insert    = pop && !chain_status.full;
   assign chain_ctrl.shift_out = drain_fire;

   isort_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .chain_ctrl   (chain_ctrl),
      .ins_value    (q_item.value),
      .chain_status (chain_status)
   );

   // Sequencing and overflow flag.
   always_comb begin
      state_in   = state_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_INSERT: begin
            if (pop) begin
               if (chain_status.full) begin
                  dropped_in = 1'b1;
               end
               if (q_item.end_of_set) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (drain_fire && last_out) begin
               state_in   = ST_INSERT;
               dropped_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_INSERT;
         end
      endcase
   end

   // Result register decouples the chain from a stalled consumer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (drain_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INSERT;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (drain_fire) begin
         rsp_sorted_value_ff <= chain_status.head;
         rsp_final_res_ff    <= last_out;
         rsp_overflow_ff     <= dropped_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_sorted_value_ff;
   assign rsp_final_res    = rsp_final_res_ff;
   assign rsp_overflow     = rsp_overflow_ff;

   // Checks on the back controller and the chain.
   `ISORT_ASSERT_NEVER(a_count_bound, clock, reset, chain_status.count > CNT_W'(CAPACITY))
   `ISORT_ASSERT(a_no_pop_in_drain, clock, reset, (state_ff == ST_DRAIN) |-> !pop)
   `ISORT_ASSERT(a_drain_nonempty, clock, reset, (state_ff == ST_DRAIN) |-> (chain_status.count != '0))
   `ISORT_ASSERT(a_final_ends_set, clock, reset, (drain_fire && last_out) |=> (state_ff == ST_INSERT && rsp_valid_ff && rsp_final_res_ff && !dropped_ff))

endmodule
